[design/dcsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dcsr_pkg;

  localparam int AMOUNT_BITS      = 64;
  localparam int HIGH_LIMB_BITS   = 32;
  localparam int HIGH_LIMB_DIGITS = 10;
  localparam int BCD_BITS         = 4;
  localparam int POS_BITS         = 7;
  localparam int OFFSET_BITS      = 3;
  localparam int CHIP_SHIFT       = 3;
  localparam int DOT_SPACING      = 3;
  localparam int STEP_BITS        = 7;
  localparam int STEPS_LOW        = 64;
  localparam int STEPS_HIGH       = 32;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_SHOW = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic [AMOUNT_BITS-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic [BCD_BITS-1:0] digit;
    logic                blank;
    logic                dot;
    logic                last;
  } disp_t;

  typedef struct packed {
    logic                   go;
    logic [AMOUNT_BITS-1:0] amount;
  } add_req_t;

  typedef struct packed {
    logic                   start;
    logic                   wide;
    logic [AMOUNT_BITS-1:0] value;
  } dd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dd_stat_t;

endpackage

`default_nettype wire

[design/decimal_counter_seven_segment_render.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Word
// cmd       in         cmd_valid/cmd_stall   cmd_t: kind, amount
// disp      out        disp_valid/disp_stall disp_t: position, digit, blank, dot, last
// cfg       in         cfg_write_en          cfg_write_data: display offset
//
// For an add word, the wide add is registered first and the base compare follows it.
// A show word runs through the shared shift-and-add-3 unit (one bit per cycle, low limb
// then high limb), and then each display word is held until it is taken.
// The command side stalls until the last display word of a run is taken.
// Reset is synchronous and clears the counter and the display offset.

module decimal_counter_seven_segment_render
  import dcsr_pkg::*;
#(
  parameter int DISPLAY_DIGITS  = 20,
  parameter int LOW_LIMB_DIGITS = 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  cmd_t                   cmd,
  output logic                   disp_valid,
  input  logic                   disp_stall,
  output disp_t                  disp,
  input  logic                   cfg_write_en,
  input  logic [OFFSET_BITS-1:0] cfg_write_data
);

  localparam int BCD_DIGITS   = (LOW_LIMB_DIGITS > HIGH_LIMB_DIGITS) ?
                                LOW_LIMB_DIGITS : HIGH_LIMB_DIGITS;
  localparam int LOW_BITS     = LOW_LIMB_DIGITS * BCD_BITS;
  localparam int STORE_BITS   = (LOW_LIMB_DIGITS + HIGH_LIMB_DIGITS) * BCD_BITS;
  localparam int K_BITS       = (DISPLAY_DIGITS > 1) ? $clog2(DISPLAY_DIGITS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_LOW  = 3'd2;
  localparam logic [2:0] S_HIGH = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]                      state;
  logic [2:0]                      state_next;
  logic [OFFSET_BITS-1:0]          display_offset;
  logic [STORE_BITS-1:0]           store;
  logic [K_BITS-1:0]               k;
  logic [1:0]                      dot_phase;
  logic [POS_BITS-1:0]             pos;
  logic                            cmd_accept;
  logic                            disp_accept;
  logic                            shown;
  logic [AMOUNT_BITS-1:0]          low_limb;
  logic [HIGH_LIMB_BITS-1:0]       high_limb;
  add_req_t                        add_req;
  dd_req_t                         dd_req;
  dd_stat_t                        dd_stat;
  logic [BCD_DIGITS*BCD_BITS-1:0]  bcd;

  assign cmd_stall   = (state != S_IDLE);
  assign cmd_accept  = cmd_valid && !cmd_stall;
  assign disp_valid  = (state == S_EMIT);
  assign disp_accept = disp_valid && !disp_stall;

  assign add_req.go     = cmd_accept && (cmd.kind == KIND_ADD);
  assign add_req.amount = cmd.amount;

  assign dd_req.start = (cmd_accept && (cmd.kind == KIND_SHOW)) ||
                        ((state == S_LOW) && dd_stat.done);
  assign dd_req.wide  = (state == S_IDLE);
  assign dd_req.value = (state == S_IDLE) ? low_limb :
                        {high_limb, (AMOUNT_BITS-HIGH_LIMB_BITS)'(0)};

  dcsr_limbs #(
    .LOW_LIMB_DIGITS(LOW_LIMB_DIGITS)
  ) u_limbs (
    .clk      (clk),
    .rst      (rst),
    .add_req  (add_req),
    .low_limb (low_limb),
    .high_limb(high_limb)
  );

  dcsr_dabble #(
    .BCD_DIGITS(BCD_DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .dd_req (dd_req),
    .dd_stat(dd_stat),
    .bcd    (bcd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          state_next = (cmd.kind == KIND_SHOW) ? S_LOW : S_ADD;
        end
      end
      S_ADD: state_next = S_IDLE;
      S_LOW: begin
        if (dd_stat.done) begin
          state_next = S_HIGH;
        end
      end
      S_HIGH: begin
        if (dd_stat.done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (disp_accept && disp.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      display_offset <= '0;
      k              <= '0;
      dot_phase      <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        display_offset <= cfg_write_data;
      end
      if ((state == S_HIGH) && dd_stat.done) begin
        k         <= '0;
        dot_phase <= '0;
      end else if (disp_accept) begin
        k         <= k + K_BITS'(1);
        dot_phase <= (dot_phase == 2'(DOT_SPACING-1)) ? 2'd0 : dot_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_LOW) && dd_stat.done) begin
      store[LOW_BITS-1:0] <= bcd[LOW_BITS-1:0];
    end
    if ((state == S_HIGH) && dd_stat.done) begin
      store[STORE_BITS-1:LOW_BITS] <= bcd[HIGH_LIMB_DIGITS*BCD_BITS-1:0];
      pos <= POS_BITS'({display_offset, CHIP_SHIFT'(0)}) + POS_BITS'(DISPLAY_DIGITS-1);
    end else if (disp_accept) begin
      store <= store >> BCD_BITS;
      pos   <= pos - POS_BITS'(1);
    end
  end

  assign shown         = (k == '0) || (store != '0);
  assign disp.position = pos;
  assign disp.digit    = shown ? store[BCD_BITS-1:0] : '0;
  assign disp.blank    = !shown;
  assign disp.dot      = shown && (k != '0) && (dot_phase == 2'd0);
  assign disp.last     = (k == K_BITS'(DISPLAY_DIGITS-1));

`ifndef NO_ASSERTIONS
  a_done_while_waiting: assert property (@(posedge clk) disable iff (rst)
    dd_stat.done |-> ((state == S_LOW) || (state == S_HIGH)))
    else $error("Conversion finished outside a render.");

  a_blank_stays: assert property (@(posedge clk) disable iff (rst)
    (disp_accept && disp.blank && !disp.last) |=> disp.blank)
    else $error("A digit was shown above a blanked slot.");

  a_last_frees_cmd: assert property (@(posedge clk) disable iff (rst)
    (disp_accept && disp.last) |=> !cmd_stall)
    else $error("Command side still stalled after the last display word.");
`endif

endmodule

`default_nettype wire

[design/dcsr_limbs.sv]
`timescale 1ns / 1ps
`default_nettype none

module dcsr_limbs
  import dcsr_pkg::*;
#(
  parameter int LOW_LIMB_DIGITS = 19
) (
  input  logic                      clk,
  input  logic                      rst,
  input  add_req_t                  add_req,
  output logic [AMOUNT_BITS-1:0]    low_limb,
  output logic [HIGH_LIMB_BITS-1:0] high_limb
);

  function automatic logic [AMOUNT_BITS-1:0] pow10(input int n);
    logic [AMOUNT_BITS-1:0] p;
    p = AMOUNT_BITS'(1);
    for (int i = 0; i < n; i++) begin
      p = p * AMOUNT_BITS'(10);
    end
    return p;
  endfunction

  localparam logic [AMOUNT_BITS-1:0] BASE = pow10(LOW_LIMB_DIGITS);

  logic [AMOUNT_BITS:0] sum;
  logic                 pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      low_limb  <= '0;
      high_limb <= '0;
    end else begin
      pending <= add_req.go && (add_req.amount < BASE);
      if (pending) begin
        if (sum >= {1'b0, BASE}) begin
          low_limb  <= AMOUNT_BITS'(sum - {1'b0, BASE});
          high_limb <= high_limb + HIGH_LIMB_BITS'(1);
        end else begin
          low_limb <= sum[AMOUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_req.go) begin
      sum <= {1'b0, low_limb} + {1'b0, add_req.amount};
    end
  end

`ifndef NO_ASSERTIONS
  a_low_in_range: assert property (@(posedge clk) disable iff (rst)
    low_limb < BASE)
    else $error("Low limb left its base.");

  a_pending_single: assert property (@(posedge clk) disable iff (rst)
    pending |=> !pending)
    else $error("An addition stayed pending for two cycles.");

  a_high_only_on_add: assert property (@(posedge clk) disable iff (rst)
    (!$past(pending) && !$past(rst)) |-> $stable(high_limb))
    else $error("High limb changed without an addition.");
`endif

endmodule

`default_nettype wire

[design/dcsr_dabble.sv]
`timescale 1ns / 1ps
`default_nettype none

module dcsr_dabble
  import dcsr_pkg::*;
#(
  parameter int BCD_DIGITS = 19
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dd_req_t                        dd_req,
  output dd_stat_t                       dd_stat,
  output logic [BCD_DIGITS*BCD_BITS-1:0] bcd
);

  localparam int BCD_WIDTH = BCD_DIGITS * BCD_BITS;

  logic [AMOUNT_BITS-1:0] bin;
  logic [BCD_WIDTH-1:0]   adjusted;
  logic [STEP_BITS-1:0]   steps;
  logic                   busy;
  logic                   done;

  always_comb begin
    logic [BCD_BITS-1:0] d;
    adjusted = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d = bcd[i*BCD_BITS +: BCD_BITS];
      adjusted[i*BCD_BITS +: BCD_BITS] = (d >= BCD_BITS'(5)) ? d + BCD_BITS'(3) : d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (dd_req.start) begin
        busy  <= 1'b1;
        steps <= dd_req.wide ? STEP_BITS'(STEPS_LOW) : STEP_BITS'(STEPS_HIGH);
      end else if (busy) begin
        steps <= steps - STEP_BITS'(1);
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dd_req.start) begin
      bin <= dd_req.value;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[AMOUNT_BITS-2:0], 1'b0};
      bcd <= {adjusted[BCD_WIDTH-2:0], bin[AMOUNT_BITS-1]};
    end
  end

  assign dd_stat.busy = busy;
  assign dd_stat.done = done;

`ifndef NO_ASSERTIONS
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    dd_req.start |-> !busy)
    else $error("Conversion started while the unit was busy.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Done held for more than one cycle.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("Done raised without a running conversion.");
`endif

endmodule

`default_nettype wire
